>>> src/vertical_luma_gradient_defines.svh
// Assertion macros for the vertical luma gradient block.
// Each check is sampled on the rising edge of clk and is off during reset.
`ifndef VERTICAL_LUMA_GRADIENT_DEFINES_SVH
`define VERTICAL_LUMA_GRADIENT_DEFINES_SVH

`ifndef ASSERT_OFF
// The condition holds in every cycle outside reset.
`define VLG_ASSERT_HOLDS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// When the trigger holds, the outcome holds in the next cycle.
`define VLG_ASSERT_NEXT(lbl, trig, outcome, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (outcome)) \
		else $error(msg);
`else
`define VLG_ASSERT_HOLDS(lbl, cond, msg)
`define VLG_ASSERT_NEXT(lbl, trig, outcome, msg)
`endif

`endif

>>> src/vlg_pkg.sv
package vlg_pkg;

	// Default depth of the line store in pixels.
	localparam int MAX_LINE_WIDTH_DEF = 4096;

	// Register field widths.
	localparam int LINE_WIDTH_W   = 13;
	localparam int FRAME_HEIGHT_W = 16;
	localparam int LUMA_W         = 16;
	localparam int GRAD_W         = 17;
	localparam int STORE_W        = 32;

	// Register reset values.
	localparam logic [LINE_WIDTH_W-1:0]   LINE_WIDTH_RST   = 13'd1920;
	localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd1080;
	localparam logic                      LUMA_DEPTH_RST   = 1'b0;

	// Position of the 8-bit luma in the first word.
	localparam int LUMA8_LSB = 16;

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		REG_LINE_WIDTH   = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_LUMA_DEPTH   = 2'd2
	} reg_index_t;

	// Input word: one packed pixel.
	typedef struct packed {
		logic [31:0] pixel_word0;
		logic [31:0] pixel_word1;
	} pixel_in_t;

	// Output word: one gradient result.
	typedef struct packed {
		logic signed [GRAD_W-1:0] gradient;
		logic                     run_last;
		logic                     frame_last;
	} grad_out_t;

endpackage

>>> src/vertical_luma_gradient.sv
// Vertical luma gradient over a raster stream of packed pixels.
// The pix channel takes one pixel word per cycle (pix_valid / pix_stall); the
// grad channel delivers signed 17-bit gradients (grad_valid / grad_stall).
// Luma is bits 23:16 of pixel_word0 or bits 15:0 of pixel_word1, chosen by
// the depth register on the APB port (line width at 0x0, frame height at
// 0x4, depth mode at 0x8). The user writes registers only while the block is
// idle; the block does not enforce this. Results run one line behind the input:
// row 0 and inner rows are emitted while the following line streams in, and each
// pixel of the last line gives two words, the inner-row gradient and the one-sided
// last-row gradient. An accepted pixel is registered in stage one with its store
// read; its first word then moves to the output register. The block takes one
// pixel per cycle while grad is not stalled; on the last line each pixel's second
// word waits in the pending slot and holds the next pixel in stage one. The
// two-line store is one synchronous memory, read on accept and written when stage
// one moves on, with a bypass when the same column is read and written in the same
// cycle (narrow lines). Reset clears the line and row position, the pipeline and
// the output valid flags; the store is not cleared, since no value read from an
// unwritten entry reaches a result. While the receiver stalls, the output word
// holds and pix_stall rises as soon as the pipeline is full.
`include "vertical_luma_gradient_defines.svh"

module vertical_luma_gradient
	import vlg_pkg::*;
#(
	parameter int MaxLineWidth = MAX_LINE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pix_valid,
	output logic        pix_stall,
	input  pixel_in_t   pix,
	output logic        grad_valid,
	input  logic        grad_stall,
	output grad_out_t   grad,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int ColW = $clog2(MaxLineWidth);
	localparam int CmpW = (ColW + 1 > LINE_WIDTH_W) ? ColW + 1 : LINE_WIDTH_W;

	// Configuration registers.
	logic [LINE_WIDTH_W-1:0]   line_width_q;
	logic [FRAME_HEIGHT_W-1:0] frame_height_q;
	logic                      luma_depth_q;
	logic                      cfg_wr;
	reg_index_t                cfg_idx;

	// Position counters.
	logic [ColW-1:0]           col_q;
	logic [FRAME_HEIGHT_W-1:0] row_q;

	// Stage one.
	logic                      valid_s1;
	logic [ColW-1:0]           col_s1;
	logic [LUMA_W-1:0]         y_s1;
	logic                      row_zero_s1;
	logic                      row_one_s1;
	logic                      last_row_s1;
	logic                      last_col_s1;
	logic                      fwd_s1;
	logic [STORE_W-1:0]        fwd_data_s1;

	// Line store.
	logic [STORE_W-1:0]        store_mem [MaxLineWidth];
	logic [STORE_W-1:0]        rd_q;

	// Output words.
	logic                      out_valid_q;
	grad_out_t                 out_q;
	logic                      pend_valid_q;
	grad_out_t                 pend_q;

	// Combinational signals.
	logic                      pix_acc;
	logic                      s1_go;
	logic                      drain;
	logic [LUMA_W-1:0]         y_in;
	logic [CmpW-1:0]           eff_w;
	logic [CmpW-1:0]           col_plus;
	logic [FRAME_HEIGHT_W-1:0] eff_h;
	logic                      last_col;
	logic                      last_row;
	logic [STORE_W-1:0]        entry;
	logic [LUMA_W-1:0]         prev1;
	logic [LUMA_W-1:0]         prev2;
	logic [STORE_W-1:0]        wdata;
	logic                      have_a;
	logic                      two_res;
	logic                      frame_end;
	grad_out_t                 res0;
	grad_out_t                 res1;

	// APB access: always ready, register index from the word address.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_index_t'(paddr[3:2]);

	always_comb begin
		unique case (cfg_idx)
			REG_LINE_WIDTH:   prdata = 32'(line_width_q);
			REG_FRAME_HEIGHT: prdata = 32'(frame_height_q);
			REG_LUMA_DEPTH:   prdata = 32'(luma_depth_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= LINE_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			luma_depth_q   <= LUMA_DEPTH_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_LINE_WIDTH:   line_width_q   <= pwdata[LINE_WIDTH_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[FRAME_HEIGHT_W-1:0];
				REG_LUMA_DEPTH:   luma_depth_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Handshake: stage one moves on only when both output slots will be free.
	assign drain     = out_valid_q && !grad_stall;
	assign s1_go     = valid_s1 && !pend_valid_q && (!out_valid_q || drain);
	assign pix_stall = valid_s1 && !s1_go;
	assign pix_acc   = pix_valid && !pix_stall;

	// Luma extraction and line/frame position of the incoming pixel.
	always_comb begin
		if (luma_depth_q) begin
			y_in = pix.pixel_word1[LUMA_W-1:0];
		end else begin
			y_in = LUMA_W'(pix.pixel_word0[LUMA8_LSB +: 8]);
		end
		eff_w = CmpW'(line_width_q);
		if (eff_w == '0) begin
			eff_w = CmpW'(1);
		end else if (eff_w > CmpW'(MaxLineWidth)) begin
			eff_w = CmpW'(MaxLineWidth);
		end
		col_plus = CmpW'(col_q) + CmpW'(1);
		last_col = col_plus >= eff_w;
		eff_h    = (frame_height_q < FRAME_HEIGHT_W'(2)) ? FRAME_HEIGHT_W'(2) : frame_height_q;
		last_row = row_q >= (eff_h - FRAME_HEIGHT_W'(1));
	end

	// Position counters and stage one control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			if (pix_acc) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + FRAME_HEIGHT_W'(1);
				end else begin
					col_q <= col_plus[ColW-1:0];
				end
				// A write to the same column in this cycle is not seen by the read.
				fwd_s1 <= s1_go && (col_s1 == col_q);
			end
			if (pix_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			col_s1      <= col_q;
			y_s1        <= y_in;
			row_zero_s1 <= row_q == '0;
			row_one_s1  <= row_q == FRAME_HEIGHT_W'(1);
			last_row_s1 <= last_row;
			last_col_s1 <= last_col;
			fwd_data_s1 <= wdata;
		end
	end

	// Line store: read on accept, write back when stage one moves on.
	always_ff @(posedge clk) begin
		if (s1_go) begin
			store_mem[col_s1] <= wdata;
		end
		if (pix_acc) begin
			rd_q <= store_mem[col_q];
		end
	end

	// Gradient results of the pixel in stage one.
	always_comb begin
		entry     = fwd_s1 ? fwd_data_s1 : rd_q;
		prev1     = entry[LUMA_W-1:0];
		prev2     = entry[STORE_W-1:LUMA_W];
		wdata     = {prev1, y_s1};
		have_a    = !row_zero_s1;
		two_res   = have_a && last_row_s1;
		frame_end = last_row_s1 && last_col_s1;

		res1.gradient   = signed'({1'b0, y_s1} - {1'b0, prev1});
		res1.run_last   = 1'b1;
		res1.frame_last = frame_end;

		if (have_a) begin
			res0.gradient = row_one_s1 ? res1.gradient
				: signed'({1'b0, y_s1} - {1'b0, prev2});
		end else begin
			res0.gradient = res1.gradient;
		end
		res0.run_last   = !two_res;
		res0.frame_last = !two_res && frame_end;
	end

	// Output register and a second slot for the extra last-row word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (s1_go) begin
			out_valid_q  <= have_a || last_row_s1;
			pend_valid_q <= two_res;
		end else if (drain) begin
			out_valid_q  <= pend_valid_q;
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			out_q  <= res0;
			pend_q <= res1;
		end else if (drain) begin
			out_q <= pend_q;
		end
	end

	assign grad_valid = out_valid_q;
	assign grad       = out_q;

	// Checks on the pipeline and output slots.
	`VLG_ASSERT_HOLDS(a_pend_behind_out, !pend_valid_q || out_valid_q, "lone pending word")
	`VLG_ASSERT_NEXT(a_acc_fills_s1, pix_acc, valid_s1, "accepted pixel missing in stage one")
	`VLG_ASSERT_NEXT(a_last_row_two, s1_go && two_res, out_valid_q && pend_valid_q, "missing word")
	`VLG_ASSERT_HOLDS(a_frame_end_run, !(out_valid_q && out_q.frame_last) || out_q.run_last, "early end")

endmodule

>>> verif/tb_vertical_luma_gradient.sv
import vlg_pkg::*;

// Tracks the expected gradient words of the block. It keeps its own copy of the
// registers, the line position and the two-line luma store.
class grad_scoreboard;
	bit [LINE_WIDTH_W-1:0]   width_reg;
	bit [FRAME_HEIGHT_W-1:0] height_reg;
	bit                      depth_reg;
	int unsigned             column_pos;
	int unsigned             row_pos;
	bit [STORE_W-1:0]        luma_lines [MAX_LINE_WIDTH_DEF];
	grad_out_t               expected_words [$];
	int                      faults;

	function new();
		width_reg  = LINE_WIDTH_RST;
		height_reg = FRAME_HEIGHT_RST;
		depth_reg  = LUMA_DEPTH_RST;
		column_pos = 0;
		row_pos    = 0;
		faults     = 0;
	endfunction

	// A width of zero acts as one, and widths past the store depth saturate.
	function int unsigned active_width();
		if (width_reg == 0)
			return 1;
		if (width_reg > MAX_LINE_WIDTH_DEF)
			return MAX_LINE_WIDTH_DEF;
		return width_reg;
	endfunction

	// Frames always have at least two lines.
	function int unsigned active_height();
		return (height_reg < 2) ? 2 : height_reg;
	endfunction

	function int unsigned pending();
		return expected_words.size();
	endfunction

	function void set_reg(reg_index_t idx, bit [31:0] value);
		case (idx)
			REG_LINE_WIDTH:   width_reg  = value[LINE_WIDTH_W-1:0];
			REG_FRAME_HEIGHT: height_reg = value[FRAME_HEIGHT_W-1:0];
			REG_LUMA_DEPTH:   depth_reg  = value[0];
			default: ;
		endcase
	endfunction

	// The difference wraps to 17 bits, which is its signed value for 16-bit luma.
	function bit [GRAD_W-1:0] luma_diff(bit [LUMA_W-1:0] a, bit [LUMA_W-1:0] b);
		return {1'b0, a} - {1'b0, b};
	endfunction

	// Works out the words caused by one accepted pixel and advances the position.
	function void note_pixel(pixel_in_t p);
		int unsigned w;
		int unsigned h;
		int unsigned col;
		int unsigned n;
		bit [LUMA_W-1:0] y;
		bit [LUMA_W-1:0] prev1;
		bit [LUMA_W-1:0] prev2;
		bit last_row;
		bit last_col;
		grad_out_t words [2];

		w = active_width();
		h = active_height();
		col = (column_pos >= MAX_LINE_WIDTH_DEF) ? MAX_LINE_WIDTH_DEF - 1 : column_pos;
		y = depth_reg ? p.pixel_word1[LUMA_W-1:0] : {8'h00, p.pixel_word0[LUMA8_LSB +: 8]};
		prev1 = luma_lines[col][LUMA_W-1:0];
		prev2 = luma_lines[col][STORE_W-1:LUMA_W];
		last_row = row_pos >= h - 1;
		last_col = column_pos + 1 >= w;
		n = 0;

		// Row 1 looks back one line; deeper rows take the central difference.
		if (row_pos != 0) begin
			words[0] = '0;
			words[0].gradient = (row_pos == 1) ? luma_diff(y, prev1) : luma_diff(y, prev2);
			n = 1;
		end
		// The last line also closes the frame with a one-sided difference.
		if (last_row) begin
			words[n] = '0;
			words[n].gradient = luma_diff(y, prev1);
			n++;
		end
		if (n > 0) begin
			words[n-1].run_last = 1'b1;
			words[n-1].frame_last = last_row && last_col;
		end
		for (int i = 0; i < n; i++)
			expected_words.push_back(words[i]);

		luma_lines[col] = {prev1, y};
		if (last_col) begin
			column_pos = 0;
			row_pos = last_row ? 0 : ((row_pos + 1) & 16'hFFFF);
		end else begin
			column_pos++;
		end
	endfunction

	// Compares one accepted gradient word with the oldest expectation.
	function void check_word(grad_out_t got);
		grad_out_t want;

		if (expected_words.size() == 0) begin
			$display("%0t: unexpected gradient word %0d run_last %0b frame_last %0b",
				$time, got.gradient, got.run_last, got.frame_last);
			faults++;
			return;
		end
		want = expected_words.pop_front();
		if (got.gradient !== want.gradient || got.run_last !== want.run_last ||
				got.frame_last !== want.frame_last) begin
			$display("%0t: gradient word mismatch, expected %0d/%0b/%0b, got %0d/%0b/%0b",
				$time, want.gradient, want.run_last, want.frame_last,
				got.gradient, got.run_last, got.frame_last);
			faults++;
		end
	endfunction
endclass

module tb_vertical_luma_gradient;
	import vlg_pkg::*;

	localparam int SETTLE_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        pix_valid;
	logic        pix_stall;
	pixel_in_t   pix;
	logic        grad_valid;
	logic        grad_stall = 1'b0;
	grad_out_t   grad;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	grad_scoreboard board = new();
	bit calm = 1'b0;
	int unsigned gap_pct = 10;
	int unsigned stall_pct = 10;
	int unsigned stall_left = 0;

	vertical_luma_gradient dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pix        (pix),
		.grad_valid (grad_valid),
		.grad_stall (grad_stall),
		.grad       (grad),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #10 clk = ~clk;

	// Both channels are sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n && pix_valid && !pix_stall)
			board.note_pixel(pix);
		if (arst_n && grad_valid && !grad_stall)
			board.check_word(grad);
	end

	// The receiver stalls in random bursts, and never in the calm stretch.
	always @(negedge clk) begin
		if (calm) begin
			grad_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			grad_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			grad_stall <= 1'b1;
			stall_left <= $urandom_range(0, 15);
		end else begin
			grad_stall <= 1'b0;
		end
	end

	// Random words, with the 8-bit luma field set to the low byte of the value and the 16-bit field to all of it.
	function automatic pixel_in_t luma_pixel(bit [LUMA_W-1:0] luma);
		pixel_in_t p;

		p.pixel_word0 = $urandom;
		p.pixel_word1 = $urandom;
		p.pixel_word0[LUMA8_LSB +: 8] = luma[7:0];
		p.pixel_word1[LUMA_W-1:0] = luma;
		return p;
	endfunction

	// Mostly random words, with the luma extremes now and then.
	function automatic pixel_in_t random_pixel();
		pixel_in_t p;

		case ($urandom_range(0, 7))
			0: p = luma_pixel('0);
			1: p = luma_pixel('1);
			default: begin
				p.pixel_word0 = $urandom;
				p.pixel_word1 = $urandom;
			end
		endcase
		return p;
	endfunction

	// Offers one pixel word, now and then after a random gap outside the calm stretch, and returns once it is taken.
	task automatic send_pixel(pixel_in_t word);
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		pix <= word;
		pix_valid <= 1'b1;
		do @(posedge clk); while (pix_stall);
		@(negedge clk);
	endtask

	task automatic send_random(int unsigned count);
		repeat (count) send_pixel(random_pixel());
	endtask

	// Holds off the sender until every expected word is in and the pipeline is empty.
	task automatic drain();
		pix_valid <= 1'b0;
		while (board.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes a register, then reads it back.
	task automatic write_reg(reg_index_t idx, logic [31:0] value);
		logic [31:0] readback;

		paddr <= {idx, 2'b00};
		pwdata <= value;
		pwrite <= 1'b1;
		psel <= 1'b1;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.set_reg(idx, value);
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (readback !== value) begin
			$display("%0t: register %s read back, expected %0d, got %0d",
				$time, idx.name(), value, readback);
			board.faults++;
		end
	endtask

	initial begin
		bit [LUMA_W-1:0] luma8_frame [9];
		bit [LUMA_W-1:0] luma16_frame [4];
		int unsigned random_count;
		int unsigned frame_pixels;
		int unsigned split;
		logic [31:0] width_pick;

		luma8_frame = '{16'h00, 16'hFF, 16'h80, 16'hFF, 16'h00,
			16'h7F, 16'h00, 16'hFF, 16'h80};
		luma16_frame = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000};
		arst_n = 1'b0;
		pix_valid = 1'b0;
		pix = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// A 3x3 frame of 8-bit luma with mostly full-scale steps between lines.
		write_reg(REG_LINE_WIDTH, 3);
		write_reg(REG_FRAME_HEIGHT, 3);
		write_reg(REG_LUMA_DEPTH, 0);
		foreach (luma8_frame[i])
			send_pixel(luma_pixel(luma8_frame[i]));
		drain();

		// A two-line frame of 16-bit luma reaches both ends of the gradient range.
		write_reg(REG_LINE_WIDTH, 2);
		write_reg(REG_FRAME_HEIGHT, 2);
		write_reg(REG_LUMA_DEPTH, 1);
		foreach (luma16_frame[i])
			send_pixel(luma_pixel(luma16_frame[i]));
		drain();

		// The width shrinks below the column in the middle of the first line.
		write_reg(REG_LINE_WIDTH, 6);
		write_reg(REG_FRAME_HEIGHT, 3);
		write_reg(REG_LUMA_DEPTH, 0);
		send_random(4);
		drain();
		write_reg(REG_LINE_WIDTH, 2);
		send_random(5);
		drain();

		// Widest line setting and tallest frame. A zero width then cuts the first line
		// short and makes the next line a single pixel, and a zero height leaves the
		// row count past the last row.
		gap_pct = 5;
		stall_pct = 5;
		write_reg(REG_LINE_WIDTH, 13'h1FFF);
		write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
		write_reg(REG_LUMA_DEPTH, $urandom_range(0, 1));
		send_random(40);
		drain();
		write_reg(REG_LINE_WIDTH, 0);
		send_random(2);
		drain();
		write_reg(REG_FRAME_HEIGHT, 0);
		write_reg(REG_LUMA_DEPTH, !board.depth_reg);
		send_random(1);
		drain();

		// Random frames over many small settings; the last stretch runs without random gaps or receiver stalls.
		random_count = 0;
		while (random_count < 300) begin
			calm = random_count >= 225;
			gap_pct = $urandom_range(0, 30);
			stall_pct = $urandom_range(0, 30);
			case ($urandom_range(0, 9))
				0: width_pick = 0;
				1: width_pick = 1;
				8, 9: width_pick = $urandom_range(9, 24);
				default: width_pick = $urandom_range(2, 8);
			endcase
			write_reg(REG_LINE_WIDTH, width_pick);
			write_reg(REG_FRAME_HEIGHT, $urandom_range(0, 5));
			write_reg(REG_LUMA_DEPTH, $urandom_range(0, 1));
			frame_pixels = board.active_width() * board.active_height() * $urandom_range(1, 2);
			if (frame_pixels > 1 && $urandom_range(0, 2) == 0) begin
				split = $urandom_range(1, frame_pixels - 1);
				send_random(split);
				drain();
				send_random(frame_pixels - split);
			end else begin
				send_random(frame_pixels);
			end
			random_count += frame_pixels;
			drain();
		end

		if (board.faults == 0)
			$display("tb_vertical_luma_gradient OK");
		else
			$display("tb_vertical_luma_gradient NOT OK");
		$finish;
	end

	// Ends a run that has stopped making progress.
	initial begin
		#60000000;
		$display("tb_vertical_luma_gradient NOT OK");
		$finish;
	end

endmodule
